// File: rtl/assert_macros.svh
// assertion macros used by the converter's top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent holds, consequent must hold in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// antecedent holds, consequent must hold in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/lch_pkg.sv
// shared types, constants and the angle table of the lab to lch converter
package lch_pkg;

	// vector rotation datapath widths
	localparam int XY_W     = 41;
	localparam int Z_W      = 34;
	localparam int VEC_FRAC = 30;

	// chroma normalization divisor 2*127*127 and its width
	localparam int CHROMA_DIV = 32258;
	localparam int DIV_W      = 15;

	// reciprocal of 255 for the lightness rounding term
	localparam int          LIGHT_SHIFT = 24;
	localparam logic [16:0] LIGHT_RECIP = 17'd65794;

	// half and full turn in angle units of 2^-32 turn
	localparam logic signed [Z_W-1:0] HALF_TURN = Z_W'(64'h0000_0000_8000_0000);
	localparam logic signed [Z_W:0]   FULL_TURN = (Z_W+1)'(64'h0000_0001_0000_0000);

	// rotation state of one item
	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} rot_t;

	// data that rides along the pipeline untouched
	typedef struct packed {
		logic [7:0]  light;
		logic [15:0] frac;
		logic        zero;
	} side_t;

	// atan(2^-i) in turns times 2^32
	function automatic logic [29:0] angle_step(input int idx);
		logic [29:0] ang;
		case (idx)
			0:  ang = 30'h2000_0000;
			1:  ang = 30'h12E4_051E;
			2:  ang = 30'h09FB_385B;
			3:  ang = 30'h0511_11D4;
			4:  ang = 30'h028B_0D43;
			5:  ang = 30'h0145_D7E1;
			6:  ang = 30'h00A2_F61E;
			7:  ang = 30'h0051_7C55;
			8:  ang = 30'h0028_BE53;
			9:  ang = 30'h0014_5F2F;
			10: ang = 30'h000A_2F98;
			11: ang = 30'h0005_17CC;
			12: ang = 30'h0002_8BE6;
			13: ang = 30'h0001_45F3;
			14: ang = 30'h0000_A2FA;
			15: ang = 30'h0000_517D;
			16: ang = 30'h0000_28BE;
			17: ang = 30'h0000_145F;
			18: ang = 30'h0000_0A30;
			19: ang = 30'h0000_0518;
			20: ang = 30'h0000_028C;
			21: ang = 30'h0000_0146;
			22: ang = 30'h0000_00A3;
			23: ang = 30'h0000_0051;
			default: ang = '0;
		endcase
		return ang;
	endfunction

endpackage

// File: rtl/lch_if.sv
// valid/ready channels for lab pixels in and lch pixels out

// lab pixel channel
interface lch_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] lightness_in;
	logic [7:0] a_in;
	logic [7:0] b_in;

	modport source (output valid, output lightness_in, output a_in, output b_in, input ready);
	modport sink (input valid, input lightness_in, input a_in, input b_in, output ready);
endinterface

// lch pixel channel
interface lch_out_if #(
	parameter int OUT_BITS = 16
);
	logic                valid;
	logic                ready;
	logic [OUT_BITS-1:0] lightness_out;
	logic [OUT_BITS-1:0] chroma_out;
	logic [OUT_BITS-1:0] hue_out;

	modport source (output valid, output lightness_out, output chroma_out, output hue_out,
		input ready);
	modport sink (input valid, input lightness_out, input chroma_out, input hue_out,
		output ready);
endinterface

// File: rtl/lab_to_lch_pixel_converter.sv
// top level of the lab to lch pixel converter
//
//   channel  role  interface   fields
//   lab      in    lch_in_if   lightness_in, a_in, b_in (8 bit each)
//   lch      out   lch_out_if  lightness_out, chroma_out, hue_out (OUT_BITS each)
//
// one item per clock sustained while the lch output is not stalled; the pipeline is the
// front stage, one stage per root bit and per rotation step, and the output stage
// arst_n clears only the stage valid bits; data registers load on accept
// each stage holds when its successor is full and stalled, empty stages
// ahead of a stall still fill, so bubbles close up and nothing is dropped
`include "assert_macros.svh"

module lab_to_lch_pixel_converter
	import lch_pkg::*;
#(
	parameter int OUT_BITS       = 16,
	parameter int ROTATION_STEPS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	lch_in_if.sink     lab,
	lch_out_if.source  lch
);

	localparam int EW   = 2*OUT_BITS + 16;
	localparam int PW   = OUT_BITS + DIV_W;
	localparam int NSTG = (OUT_BITS > ROTATION_STEPS) ? OUT_BITS : ROTATION_STEPS;

	logic                stg_valid [NSTG+1];
	logic                stg_ready [NSTG+1];
	rot_t                rot_w     [NSTG+1];
	logic [EW-1:0]       rem_w     [NSTG+1];
	logic [PW-1:0]       acc_w     [NSTG+1];
	logic [OUT_BITS-1:0] root_w    [NSTG+1];
	side_t               side_w    [NSTG+1];

	// front stage
	lch_prep #(
		.OUT_BITS (OUT_BITS)
	) u_prep (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (lab.valid),
		.in_ready     (lab.ready),
		.lightness_in (lab.lightness_in),
		.a_in         (lab.a_in),
		.b_in         (lab.b_in),
		.out_valid    (stg_valid[0]),
		.out_ready    (stg_ready[0]),
		.rot_out      (rot_w[0]),
		.rem_out      (rem_w[0]),
		.side_out     (side_w[0])
	);

	// root and its square root accumulator start from zero
	assign acc_w[0]  = '0;
	assign root_w[0] = '0;

	// root bit and rotation steps
	for (genvar i = 0; i < NSTG; i++) begin : g_step
		lch_step #(
			.OUT_BITS       (OUT_BITS),
			.ROTATION_STEPS (ROTATION_STEPS),
			.IDX            (i)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stg_valid[i]),
			.in_ready  (stg_ready[i]),
			.rot_in    (rot_w[i]),
			.rem_in    (rem_w[i]),
			.acc_in    (acc_w[i]),
			.root_in   (root_w[i]),
			.side_in   (side_w[i]),
			.out_valid (stg_valid[i+1]),
			.out_ready (stg_ready[i+1]),
			.rot_out   (rot_w[i+1]),
			.rem_out   (rem_w[i+1]),
			.acc_out   (acc_w[i+1]),
			.root_out  (root_w[i+1]),
			.side_out  (side_w[i+1])
		);
	end

	// output stage
	lch_finish #(
		.OUT_BITS (OUT_BITS)
	) u_finish (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (stg_valid[NSTG]),
		.in_ready      (stg_ready[NSTG]),
		.z_in          (rot_w[NSTG].z),
		.root_in       (root_w[NSTG]),
		.side_in       (side_w[NSTG]),
		.out_valid     (lch.valid),
		.out_ready     (lch.ready),
		.lightness_out (lch.lightness_out),
		.chroma_out    (lch.chroma_out),
		.hue_out       (lch.hue_out)
	);

	// an empty output register means every stage can move, so input is open
	`ASSERT_IMPLIES(a_ready_when_drained, clk, arst_n, !lch.valid, lab.ready)
	// an accepted item always lands in the front stage
	`ASSERT_NEXT(a_accept_lands, clk, arst_n, lab.valid && lab.ready, stg_valid[0])
	// zero chroma only comes from the zero vector, whose hue is forced to zero
	`ASSERT_IMPLIES(a_zero_chroma_hue, clk, arst_n, lch.valid && lch.chroma_out == '0, lch.hue_out == '0)

endmodule

// File: rtl/lch_prep.sv
// first stage: signed components, squared magnitude, rotation start, lightness term
module lch_prep
	import lch_pkg::*;
#(
	parameter int OUT_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                lightness_in,
	input  logic [7:0]                a_in,
	input  logic [7:0]                b_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output rot_t                      rot_out,
	output logic [2*OUT_BITS+15:0]    rem_out,
	output side_t                     side_out
);

	localparam int EW      = 2*OUT_BITS + 16;
	localparam int LIGHT_R = ((1 << OUT_BITS) - 1) % 255;

	logic signed [7:0]      a_c;
	logic signed [7:0]      b_c;
	logic signed [15:0]     a_sq;
	logic signed [15:0]     b_sq;
	logic [15:0]            sum_sq;
	logic signed [XY_W-1:0] a_ext;
	logic signed [XY_W-1:0] b_ext;
	logic                   neg;
	rot_t                   rot_nx;
	side_t                  side_nx;
	logic [7:0]             r8;

	logic                   valid_s1;
	rot_t                   rot_s1;
	logic [EW-1:0]          rem_s1;
	side_t                  side_s1;

	// offset binary to two's complement
	assign a_c = signed'(a_in ^ 8'h80);
	assign b_c = signed'(b_in ^ 8'h80);

	// squared magnitude, scaled up so the root lands on OUT_BITS fraction bits
	assign a_sq   = a_c * a_c;
	assign b_sq   = b_c * b_c;
	assign sum_sq = unsigned'(a_sq) + unsigned'(b_sq);

	// fold the left half plane onto the right one before rotating
	assign a_ext = XY_W'(a_c);
	assign b_ext = XY_W'(b_c);
	assign neg   = a_c[7];

	always_comb begin
		if (neg) begin
			rot_nx.x = (-a_ext) <<< VEC_FRAC;
			rot_nx.y = (-b_ext) <<< VEC_FRAC;
			rot_nx.z = b_c[7] ? -HALF_TURN : HALF_TURN;
		end else begin
			rot_nx.x = a_ext <<< VEC_FRAC;
			rot_nx.y = b_ext <<< VEC_FRAC;
			rot_nx.z = '0;
		end
	end

	// lightness remainder term L*r + 127, divided by 255 at the end
	assign r8            = 8'(LIGHT_R);
	assign side_nx.light = lightness_in;
	assign side_nx.frac  = ({8'b0, lightness_in} * {8'b0, r8}) + 16'd127;
	assign side_nx.zero  = (a_in == 8'h80) && (b_in == 8'h80);

	// stage register
	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rot_s1  <= rot_nx;
			rem_s1  <= EW'(sum_sq) << (2*OUT_BITS);
			side_s1 <= side_nx;
		end
	end

	assign out_valid = valid_s1;
	assign rot_out   = rot_s1;
	assign rem_out   = rem_s1;
	assign side_out  = side_s1;

endmodule

// File: rtl/lch_step.sv
// one pipeline step: one root bit and one vector rotation, each where in range
module lch_step
	import lch_pkg::*;
#(
	parameter int OUT_BITS       = 16,
	parameter int ROTATION_STEPS = 16,
	parameter int IDX            = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  rot_t                      rot_in,
	input  logic [2*OUT_BITS+15:0]    rem_in,
	input  logic [OUT_BITS+14:0]      acc_in,
	input  logic [OUT_BITS-1:0]       root_in,
	input  side_t                     side_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output rot_t                      rot_out,
	output logic [2*OUT_BITS+15:0]    rem_out,
	output logic [OUT_BITS+14:0]      acc_out,
	output logic [OUT_BITS-1:0]       root_out,
	output side_t                     side_out
);

	localparam int EW     = 2*OUT_BITS + 16;
	localparam int PW     = OUT_BITS + DIV_W;
	localparam bit SQ_ON  = IDX < OUT_BITS;
	localparam bit ROT_ON = IDX < ROTATION_STEPS;
	localparam int BIT_K  = SQ_ON ? OUT_BITS - 1 - IDX : 0;

	rot_t                rot_nx;
	logic [EW-1:0]       rem_nx;
	logic [PW-1:0]       acc_nx;
	logic [OUT_BITS-1:0] root_nx;

	// registers of this step, stage IDX+2 of the pipeline
	logic                valid_sk;
	rot_t                rot_sk;
	logic [EW-1:0]       rem_sk;
	logic [PW-1:0]       acc_sk;
	logic [OUT_BITS-1:0] root_sk;
	side_t               side_sk;

	// vector rotation toward the x axis, accumulating the angle
	if (ROT_ON) begin : g_rot
		localparam logic signed [Z_W-1:0] ANG = Z_W'(angle_step(IDX));
		logic signed [XY_W-1:0] dx;
		logic signed [XY_W-1:0] dy;

		assign dx = rot_in.y >>> IDX;
		assign dy = rot_in.x >>> IDX;

		always_comb begin
			if (!rot_in.y[XY_W-1]) begin
				rot_nx.x = rot_in.x + dx;
				rot_nx.y = rot_in.y - dy;
				rot_nx.z = rot_in.z + ANG;
			end else begin
				rot_nx.x = rot_in.x - dx;
				rot_nx.y = rot_in.y + dy;
				rot_nx.z = rot_in.z - ANG;
			end
		end
	end else begin : g_rot_pass
		assign rot_nx = rot_in;
	end

	// restoring square root bit: try (c + 2^k)^2 * div against the remainder
	if (SQ_ON) begin : g_sqrt
		logic [EW-1:0] delta;
		logic          take;

		assign delta = (EW'(acc_in) << (BIT_K + 1)) + (EW'(CHROMA_DIV) << (2*BIT_K));
		assign take  = rem_in >= delta;

		assign rem_nx  = take ? rem_in - delta : rem_in;
		assign acc_nx  = take ? acc_in + (PW'(CHROMA_DIV) << BIT_K) : acc_in;
		assign root_nx = take ? root_in | (OUT_BITS'(1) << BIT_K) : root_in;
	end else begin : g_sqrt_pass
		assign rem_nx  = rem_in;
		assign acc_nx  = acc_in;
		assign root_nx = root_in;
	end

	// stage register
	assign in_ready = !valid_sk || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sk <= 1'b0;
		end else if (in_ready) begin
			valid_sk <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rot_sk  <= rot_nx;
			rem_sk  <= rem_nx;
			acc_sk  <= acc_nx;
			root_sk <= root_nx;
			side_sk <= side_in;
		end
	end

	assign out_valid = valid_sk;
	assign rot_out   = rot_sk;
	assign rem_out   = rem_sk;
	assign acc_out   = acc_sk;
	assign root_out  = root_sk;
	assign side_out  = side_sk;

endmodule

// File: rtl/lch_finish.sv
// last stage: lightness scaling, hue rounding and clamping, output register
module lch_finish
	import lch_pkg::*;
#(
	parameter int OUT_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [Z_W-1:0]     z_in,
	input  logic [OUT_BITS-1:0]       root_in,
	input  side_t                     side_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [OUT_BITS-1:0]       lightness_out,
	output logic [OUT_BITS-1:0]       chroma_out,
	output logic [OUT_BITS-1:0]       hue_out
);

	localparam int LIGHT_Q = ((1 << OUT_BITS) - 1) / 255;

	logic [32:0]         frac_prod;
	logic [OUT_BITS:0]   light_base;
	logic [OUT_BITS:0]   light_sum;
	logic signed [Z_W:0] turn;
	logic [32:0]         turn_c;
	logic [33:0]         turn_r;
	logic [OUT_BITS:0]   hue_w;
	logic [OUT_BITS-1:0] hue_nx;

	logic                valid_sf;
	logic [OUT_BITS-1:0] light_sf;
	logic [OUT_BITS-1:0] chroma_sf;
	logic [OUT_BITS-1:0] hue_sf;

	// lightness: L*q plus the remainder term divided by 255 via reciprocal
	assign frac_prod  = 33'(side_in.frac) * 33'(LIGHT_RECIP);
	assign light_base = (OUT_BITS+1)'(side_in.light) * (OUT_BITS+1)'(LIGHT_Q);
	assign light_sum  = light_base + (OUT_BITS+1)'(frac_prod[32:LIGHT_SHIFT]);

	// hue: shift angle onto 0..1 turn, clamp, round half up, saturate
	assign turn = (Z_W+1)'(z_in) + (Z_W+1)'(HALF_TURN);

	always_comb begin
		if (turn[Z_W]) begin
			turn_c = '0;
		end else if (turn > FULL_TURN) begin
			turn_c = FULL_TURN[32:0];
		end else begin
			turn_c = turn[32:0];
		end
	end

	assign turn_r = {1'b0, turn_c} + (34'd1 << (31 - OUT_BITS));
	assign hue_w  = turn_r[32:32-OUT_BITS];

	always_comb begin
		if (side_in.zero) begin
			hue_nx = '0;
		end else if (hue_w[OUT_BITS]) begin
			hue_nx = '1;
		end else begin
			hue_nx = hue_w[OUT_BITS-1:0];
		end
	end

	// output register
	assign in_ready = !valid_sf || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sf <= 1'b0;
		end else if (in_ready) begin
			valid_sf <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			light_sf  <= light_sum[OUT_BITS-1:0];
			chroma_sf <= root_in;
			hue_sf    <= hue_nx;
		end
	end

	assign out_valid     = valid_sf;
	assign lightness_out = light_sf;
	assign chroma_out    = chroma_sf;
	assign hue_out       = hue_sf;

endmodule
